// ===== rtl/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal controller.
`default_nettype none
package gtg_pkg;

  // Number of CORDIC vectoring steps by default.
  localparam int CordicStepsDef = 14;
  // Length of the arctangent table; the step count is meant not to exceed it, which the block does not enforce.
  localparam int AtanLen = 20;

  // Angle constants in Q3.12 radians.
  localparam logic signed [15:0] PiQ12    = 16'sd12868;
  localparam logic signed [16:0] PiQ12W   = 17'sd12868;
  localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;

  // Width of the sum of squares and the root iteration count.
  localparam int SqW       = 34;
  localparam int SqrtIters = SqW / 2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TURN_GAIN  = 3'd0,
    CFG_DRIVE_GAIN = 3'd1,
    CFG_ANGLE_DB   = 3'd2,
    CFG_DIST_DB    = 3'd3,
    CFG_WIN_HIGH   = 3'd4,
    CFG_WIN_LOW    = 3'd5,
    CFG_SPEED_CAP  = 3'd6
  } cfg_idx_e;

  // Controller mode, also the phase reported with each command.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TURN  = 2'd1,
    MODE_DRIVE = 2'd2
  } mode_e;

  // Input item kinds.
  typedef enum logic {
    ACT_GOAL = 1'b0,
    ACT_POSE = 1'b1
  } action_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CORD_INIT,
    S_CORD,
    S_CORD_END,
    S_ERR,
    S_TURN_MUL,
    S_TURN_FIN,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_SUM,
    S_SQRT,
    S_DIST,
    S_DRV_FIN,
    S_EMIT
  } state_e;

  // Rounded arctangent of 2^-i in Q3.12 radians.
  function automatic logic [11:0] atan_q12(input int i);
    logic [11:0] r;
    case (i)
      0:  r = 12'd3217;
      1:  r = 12'd1899;
      2:  r = 12'd1003;
      3:  r = 12'd509;
      4:  r = 12'd256;
      5:  r = 12'd128;
      6:  r = 12'd64;
      7:  r = 12'd32;
      8:  r = 12'd16;
      9:  r = 12'd8;
      10: r = 12'd4;
      11: r = 12'd2;
      12: r = 12'd1;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/go_to_goal_p_controller.sv =====
// Top level of the go-to-goal controller: turn toward the goal, then drive to it.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_ready_o | action, goal_x/y, pose_x/y/heading
//  out     | output    | out_valid_o/out_ready_i | forward_speed, turn_rate, phase, arrived
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// A goal with no known pose only stores the target; with a pose known, the
// CORDIC rotator computes the bearing. A pose computes the heading error and,
// while turning, the turn rate; driving adds the bit-pair square root loop,
// and the rotator runs first when a bearing is still owed. One multiplier is shared.
// Reset clears state and loads register defaults; the result register lets
// a new item be taken while a command waits for its transfer.
`default_nettype none
module go_to_goal_p_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [15:0] goal_x_i,
  input  wire logic signed [15:0] goal_y_i,
  input  wire logic signed [15:0] pose_x_i,
  input  wire logic signed [15:0] pose_y_i,
  input  wire logic signed [14:0] pose_heading_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [14:0]             forward_speed_o,
  output logic signed [15:0]      turn_rate_o,
  output logic [1:0]              phase_o,
  output logic                    arrived_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int MaxIters = (CORDIC_STEPS > SqrtIters) ? CORDIC_STEPS : SqrtIters;
  localparam int CntW = $clog2(MaxIters + 1);

  // Configuration registers.
  logic [15:0] turn_gain_q, drive_gain_q;
  logic [13:0] angle_db_q;
  logic [14:0] dist_db_q, speed_cap_q;
  logic signed [15:0] win_high_q, win_low_q;

  // Controller state.
  logic signed [15:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, bearing_q;
  logic signed [14:0] cur_h_q;
  logic pose_seen_q, pending_q, from_goal_q;
  mode_e mode_q;
  state_e state_q, state_d;

  // Datapath registers.
  logic [CntW-1:0] cnt_q;
  logic signed [27:0] cx_q, cy_q;
  logic signed [15:0] cz_q;
  logic [13:0] mag_q;
  logic err_neg_q;
  logic [15:0] adx_q, ady_q;
  logic [SqW-1:0] prod_q, acc_q, rem_q, bit_q;
  logic [SqW:0] root_q;
  logic [14:0] res_speed_q;
  logic signed [15:0] res_turn_q;
  logic res_arrived_q;

  // Output register.
  logic out_valid_q;
  logic [14:0] out_speed_q;
  logic signed [15:0] out_turn_q;
  logic [1:0] out_phase_q;
  logic out_arrived_q;

  logic in_fire, emit;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign emit = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Window clamp of the goal coordinates, high bound first.
  logic signed [15:0] gx_clamp, gy_clamp;
  always_comb begin
    if (goal_x_i > win_high_q) begin
      gx_clamp = win_high_q;
    end else if (goal_x_i < win_low_q) begin
      gx_clamp = win_low_q;
    end else begin
      gx_clamp = goal_x_i;
    end
    if (goal_y_i > win_high_q) begin
      gy_clamp = win_high_q;
    end else if (goal_y_i < win_low_q) begin
      gy_clamp = win_low_q;
    end else begin
      gy_clamp = goal_y_i;
    end
  end

  // Offset from the pose to the target.
  logic signed [16:0] dx, dy;
  logic [16:0] adx_w, ady_w;
  assign dx = {tgt_x_q[15], tgt_x_q} - {cur_x_q[15], cur_x_q};
  assign dy = {tgt_y_q[15], tgt_y_q} - {cur_y_q[15], cur_y_q};
  assign adx_w = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady_w = dy[16] ? 17'(-dy) : 17'(dy);

  // Wrapped heading error and its magnitude.
  logic signed [16:0] err_raw, err_w;
  logic [16:0] err_abs;
  logic [13:0] mag_w;
  always_comb begin
    err_raw = {bearing_q[15], bearing_q} - {{2{cur_h_q[14]}}, cur_h_q};
    if (err_raw > PiQ12W) begin
      err_w = err_raw - TwoPiQ12;
    end else if (err_raw <= -PiQ12W) begin
      err_w = err_raw + TwoPiQ12;
    end else begin
      err_w = err_raw;
    end
    err_abs = err_w[16] ? 17'(-err_w) : 17'(err_w);
    mag_w = err_abs[13:0];
  end

  // CORDIC rotator step.
  logic signed [27:0] xs, ys;
  logic [11:0] atan_w;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign atan_w = atan_q12(int'(cnt_q));

  // Square root step.
  logic [SqW:0] trial;
  assign trial = root_q + {1'b0, bit_q};

  // Shared multiplier.
  logic [16:0] mul_a, mul_b;
  logic [SqW-1:0] prod;
  always_comb begin
    case (state_q)
      S_TURN_MUL: begin
        mul_a = {3'b0, mag_q};
        mul_b = {1'b0, turn_gain_q};
      end
      S_SQ_X: begin
        mul_a = {1'b0, adx_q};
        mul_b = {1'b0, adx_q};
      end
      S_SQ_Y: begin
        mul_a = {1'b0, ady_q};
        mul_b = {1'b0, ady_q};
      end
      default: begin
        mul_a = root_q[16:0];
        mul_b = {1'b0, drive_gain_q};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Saturated turn rate and capped speed from the product.
  logic [21:0] turn_mag;
  logic [25:0] speed_full;
  logic signed [15:0] turn_sat;
  logic [14:0] speed_sat;
  always_comb begin
    turn_mag = prod_q[33:12];
    if (err_neg_q) begin
      turn_sat = (turn_mag > 22'd32768) ? 16'sh8000 : 16'(-turn_mag);
    end else begin
      turn_sat = (turn_mag > 22'd32767) ? 16'sh7fff : 16'(turn_mag);
    end
    speed_full = prod_q[33:8];
    speed_sat = (speed_full > 26'(speed_cap_q)) ? speed_cap_q : speed_full[14:0];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_GOAL) begin
            state_d = pose_seen_q ? S_CORD_INIT : S_IDLE;
          end else begin
            state_d = pending_q ? S_CORD_INIT : S_ERR;
          end
        end
      end
      S_CORD_INIT: state_d = (dx == '0 && dy == '0) ? S_CORD_END : S_CORD;
      S_CORD: begin
        if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
          state_d = S_CORD_END;
        end
      end
      S_CORD_END: state_d = from_goal_q ? S_IDLE : S_ERR;
      S_ERR: begin
        if (mode_q == MODE_IDLE) begin
          state_d = S_EMIT;
        end else if (mode_q == MODE_TURN && mag_w > angle_db_q) begin
          state_d = S_TURN_MUL;
        end else begin
          state_d = S_SQ_X;
        end
      end
      S_TURN_MUL: state_d = S_TURN_FIN;
      S_TURN_FIN: state_d = S_EMIT;
      S_SQ_X:     state_d = S_SQ_Y;
      S_SQ_Y:     state_d = S_SQ_SUM;
      S_SQ_SUM:   state_d = S_SQRT;
      S_SQRT: begin
        if (cnt_q == CntW'(SqrtIters - 1)) begin
          state_d = S_DIST;
        end
      end
      S_DIST:    state_d = (root_q[16:0] > {2'b0, dist_db_q}) ? S_DRV_FIN : S_EMIT;
      S_DRV_FIN: state_d = S_EMIT;
      S_EMIT: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q  <= 16'd256;
      drive_gain_q <= 16'd256;
      angle_db_q   <= 14'd41;
      dist_db_q    <= 15'd26;
      win_high_q   <= 16'sd2816;
      win_low_q    <= 16'sd0;
      speed_cap_q  <= 15'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TURN_GAIN:  turn_gain_q  <= cfg_data_i;
        CFG_DRIVE_GAIN: drive_gain_q <= cfg_data_i;
        CFG_ANGLE_DB:   angle_db_q   <= cfg_data_i[13:0];
        CFG_DIST_DB:    dist_db_q    <= cfg_data_i[14:0];
        CFG_WIN_HIGH:   win_high_q   <= cfg_data_i;
        CFG_WIN_LOW:    win_low_q    <= cfg_data_i;
        CFG_SPEED_CAP:  speed_cap_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pose, target, bearing and mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_h_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      bearing_q   <= '0;
      pose_seen_q <= 1'b0;
      pending_q   <= 1'b0;
      from_goal_q <= 1'b0;
      mode_q      <= MODE_IDLE;
    end else begin
      if (in_fire) begin
        if (action_i == ACT_GOAL) begin
          tgt_x_q     <= gx_clamp;
          tgt_y_q     <= gy_clamp;
          mode_q      <= MODE_TURN;
          from_goal_q <= 1'b1;
          if (!pose_seen_q) begin
            pending_q <= 1'b1;
          end
        end else begin
          cur_x_q     <= pose_x_i;
          cur_y_q     <= pose_y_i;
          cur_h_q     <= pose_heading_i;
          pose_seen_q <= 1'b1;
          pending_q   <= 1'b0;
          from_goal_q <= 1'b0;
        end
      end
      if (state_q == S_CORD_END) begin
        if (cz_q > PiQ12) begin
          bearing_q <= PiQ12;
        end else if (cz_q < -PiQ12) begin
          bearing_q <= -PiQ12;
        end else begin
          bearing_q <= cz_q;
        end
      end
      if (state_q == S_ERR && mode_q == MODE_TURN && mag_w <= angle_db_q) begin
        mode_q <= MODE_DRIVE;
      end
      if (state_q == S_DIST && root_q[16:0] <= {2'b0, dist_db_q}) begin
        mode_q <= MODE_IDLE;
      end
    end
  end

  // Iteration counter for the rotator and the root loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == S_CORD || state_q == S_SQRT) begin
      cnt_q <= cnt_q + CntW'(1);
    end else begin
      cnt_q <= '0;
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (state_q)
      S_CORD_INIT: begin
        if (dx < 0) begin
          cx_q <= -{{3{dx[16]}}, dx, 8'b0};
          cy_q <= -{{3{dy[16]}}, dy, 8'b0};
          cz_q <= (dy >= 0) ? PiQ12 : -PiQ12;
        end else begin
          cx_q <= {{3{dx[16]}}, dx, 8'b0};
          cy_q <= {{3{dy[16]}}, dy, 8'b0};
          cz_q <= '0;
        end
      end
      S_CORD: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + $signed({4'b0, atan_w});
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - $signed({4'b0, atan_w});
        end
      end
      S_ERR: begin
        mag_q     <= mag_w;
        err_neg_q <= err_w[16];
        adx_q     <= adx_w[15:0];
        ady_q     <= ady_w[15:0];
      end
      S_SQ_Y: acc_q <= prod_q;
      S_SQ_SUM: begin
        rem_q  <= acc_q + prod_q;
        root_q <= '0;
        bit_q  <= {2'b01, {(SqW - 2){1'b0}}};
      end
      S_SQRT: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_q  <= rem_q - trial[SqW-1:0];
          root_q <= (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  // Command staged for the output register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ERR: begin
        res_speed_q   <= '0;
        res_turn_q    <= '0;
        res_arrived_q <= 1'b0;
      end
      S_TURN_FIN: res_turn_q <= turn_sat;
      S_DIST: begin
        if (root_q[16:0] <= {2'b0, dist_db_q}) begin
          res_arrived_q <= 1'b1;
        end
      end
      S_DRV_FIN: res_speed_q <= speed_sat;
      default: ;
    endcase
  end

  // Output register and its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_speed_q   <= res_speed_q;
      out_turn_q    <= res_turn_q;
      out_phase_q   <= mode_q;
      out_arrived_q <= res_arrived_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign forward_speed_o = out_speed_q;
  assign turn_rate_o     = out_turn_q;
  assign phase_o         = out_phase_q;
  assign arrived_o       = out_arrived_q;

  // An arrival command carries no motion and reports the idle phase.
  a_arrive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrived_o |-> phase_o == MODE_IDLE && forward_speed_o == '0
                                 && turn_rate_o == '0)
    else $error("arrival command carries motion");

  // While turning the block never drives forward.
  a_turn_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == MODE_TURN |-> forward_speed_o == '0)
    else $error("forward speed while turning");

  // The rotator stops after the configured number of steps.
  a_cord_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORD |-> cnt_q < CntW'(CORDIC_STEPS))
    else $error("rotator step count overrun");

  // The root loop stops after one step per result bit.
  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> cnt_q < CntW'(SqrtIters))
    else $error("root step count overrun");

  // A command is loaded only after the previous one left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !out_valid_q || out_ready_i)
    else $error("pending command overwritten");

endmodule
`default_nettype wire

// ===== dv/go_to_goal_p_controller_checker.sv =====
// Checker for the go-to-goal controller: watches the channels, predicts each command and compares.
`timescale 1ns / 100ps
module go_to_goal_p_controller_checker
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               action_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [14:0] pose_heading_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [14:0]        forward_speed_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic [1:0]         phase_i,
  input  logic               arrived_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [14:0]        speed;
    logic signed [15:0] turn;
    logic [1:0]         phase;
    logic               arrived;
  } command_t;

  // Arctangent of 2^-i in Q3.12 radians, rounded.
  localparam int ArctanStep[20] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8,
                                    4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam int RotSteps = (CORDIC_STEPS < 20) ? CORDIC_STEPS : 20;

  // Register copies.
  logic [15:0]        turn_gain, drive_gain;
  logic [13:0]        angle_db;
  logic [14:0]        dist_db, speed_cap;
  logic signed [15:0] win_high, win_low;

  // Controller state as predicted.
  longint cur_x, cur_y, cur_heading, target_x, target_y, bearing;
  bit     pose_seen, bearing_owed;
  mode_e  mode;

  command_t expected_cmds[$];

  assign pending_o = expected_cmds.size();

  function automatic longint clamp_to_window(longint v);
    if (v > longint'(win_high)) return longint'(win_high);
    if (v < longint'(win_low)) return longint'(win_low);
    return v;
  endfunction

  // Vectoring rotation toward the x axis; arithmetic shifts give floor division.
  function automatic longint heading_to(longint dy, longint dx);
    longint x, y, z, xs, ys;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 12868 : -12868;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < RotSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ArctanStep[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ArctanStep[i];
      end
    end
    if (z > 12868) z = 12868;
    if (z < -12868) z = -12868;
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void latch_heading_to_target();
    bearing = heading_to(target_y - cur_y, target_x - cur_x);
    bearing_owed = 0;
  endfunction

  // Applies one accepted item and queues the command it yields, if any.
  function automatic void apply_item();
    longint err, dx, dy;
    longint unsigned mag, t, range_len, speed;
    command_t cmd;
    cmd = '0;
    if (action_i == ACT_GOAL) begin
      target_x = clamp_to_window(longint'(goal_x_i));
      target_y = clamp_to_window(longint'(goal_y_i));
      mode = MODE_TURN;
      if (pose_seen) latch_heading_to_target();
      else bearing_owed = 1;
      return;
    end
    cur_x = longint'(pose_x_i);
    cur_y = longint'(pose_y_i);
    cur_heading = longint'(pose_heading_i);
    pose_seen = 1;
    if (bearing_owed) latch_heading_to_target();
    if (mode == MODE_TURN) begin
      err = bearing - cur_heading;
      while (err > 12868) err = err - 25736;
      while (err <= -12868) err = err + 25736;
      mag = (err < 0) ? -err : err;
      if (mag > angle_db) begin
        t = (mag * turn_gain) >> 12;
        if (err < 0) begin
          if (t > 32768) t = 32768;
          cmd.turn = 16'(-t);
        end else begin
          if (t > 32767) t = 32767;
          cmd.turn = 16'(t);
        end
      end else begin
        mode = MODE_DRIVE;
      end
    end
    if (mode == MODE_DRIVE) begin
      dx = target_x - cur_x;
      dy = target_y - cur_y;
      range_len = root_floor(dx * dx + dy * dy);
      if (range_len > dist_db) begin
        speed = (range_len * drive_gain) >> 8;
        if (speed > speed_cap) speed = speed_cap;
        cmd.speed = 15'(speed);
      end else begin
        mode = MODE_IDLE;
        cmd.arrived = 1;
      end
    end
    cmd.phase = mode;
    expected_cmds.push_back(cmd);
  endfunction

  // Compare results first, then predict from the item taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    command_t exp_cmd;
    if (!rst_ni) begin
      turn_gain <= 16'd256;
      drive_gain <= 16'd256;
      angle_db <= 14'd41;
      dist_db <= 15'd26;
      win_high <= 16'sd2816;
      win_low <= 16'sd0;
      speed_cap <= 15'd512;
      cur_x = 0; cur_y = 0; cur_heading = 0;
      target_x = 0; target_y = 0; bearing = 0;
      pose_seen = 0;
      bearing_owed = 0;
      mode = MODE_IDLE;
      expected_cmds.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: command transfer with none expected", $time);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          if (exp_cmd.speed !== forward_speed_i || exp_cmd.turn !== turn_rate_i ||
              exp_cmd.phase !== phase_i || exp_cmd.arrived !== arrived_i) begin
            $display("%0t: speed expected %0d actual %0d, turn expected %0d actual %0d",
                     $time, exp_cmd.speed, forward_speed_i, exp_cmd.turn, turn_rate_i);
            $display("%0t: phase expected %0d actual %0d, arrived expected %0d actual %0d",
                     $time, exp_cmd.phase, phase_i, exp_cmd.arrived, arrived_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_item();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TURN_GAIN:  turn_gain <= cfg_data_i;
          CFG_DRIVE_GAIN: drive_gain <= cfg_data_i;
          CFG_ANGLE_DB:   angle_db <= cfg_data_i[13:0];
          CFG_DIST_DB:    dist_db <= cfg_data_i[14:0];
          CFG_WIN_HIGH:   win_high <= cfg_data_i;
          CFG_WIN_LOW:    win_low <= cfg_data_i;
          CFG_SPEED_CAP:  speed_cap <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== dv/go_to_goal_p_controller_test.sv =====
// Testbench top of the go-to-goal controller: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module go_to_goal_p_controller_test;
  import gtg_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 64;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o;
  logic               action_i;
  logic signed [15:0] goal_x_i, goal_y_i, pose_x_i, pose_y_i;
  logic signed [14:0] pose_heading_i;
  logic               out_valid_o, out_ready_i;
  logic [14:0]        forward_speed_o;
  logic signed [15:0] turn_rate_o;
  logic [1:0]         phase_o;
  logic               arrived_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  int                 fail_count, pending_cmds;

  // Window as written, so that aimed poses can follow the clamped target.
  int win_hi = 2816, win_lo = 0;
  int last_px = 0, last_py = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_style = 0, stall_count = 0;

  go_to_goal_p_controller dut (.*);

  go_to_goal_p_controller_checker scoreboard (
    .clk_i, .rst_ni, .in_valid_i,
    .in_ready_i(in_ready_o),
    .action_i, .goal_x_i, .goal_y_i, .pose_x_i, .pose_y_i, .pose_heading_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .forward_speed_i(forward_speed_o),
    .turn_rate_i(turn_rate_o),
    .phase_i(phase_o),
    .arrived_i(arrived_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count),
    .pending_o(pending_cmds)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls follow a style that is picked anew at random each time the stall counter wraps.
  always @(posedge clk_i) begin
    if (stall_count == 0) stall_style <= $urandom_range(0, 3);
    stall_count <= (stall_count + 1) % 97;
    case (stall_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= stall_count[0];
    endcase
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int clamp_win(int v);
    if (v > win_hi) return win_hi;
    if (v < win_lo) return win_lo;
    return v;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clip_heading(int v);
    if (v > 12868) return 12868;
    if (v < -12868) return -12868;
    return v;
  endfunction

  // Drives one item after an optional gap and waits for its transfer.
  task automatic send_item(input action_e act, input int gx, input int gy, input int px,
                           input int py, input int hd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i <= act;
    goal_x_i <= 16'(gx);
    goal_y_i <= 16'(gy);
    pose_x_i <= 16'(px);
    pose_y_i <= 16'(py);
    pose_heading_i <= 15'(hd);
    if (act == ACT_POSE) begin
      last_px = px;
      last_py = py;
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_goal(input int gx, input int gy);
    send_item(ACT_GOAL, gx, gy, $urandom, $urandom, $urandom_range(0, 25736) - 12868);
  endtask

  task automatic send_pose(input int px, input int py, input int hd);
    send_item(ACT_POSE, $urandom, $urandom, px, py, hd);
  endtask

  // Waits until every command has come and any goal still in work has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_cmds != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(val);
    if (idx == CFG_WIN_HIGH) win_hi = int'($signed(16'(val)));
    if (idx == CFG_WIN_LOW) win_lo = int'($signed(16'(val)));
    @(posedge clk_i);
  endtask

  task automatic configure(input int tg, input int dg, input int adb, input int ddb,
                           input int hi, input int lo, input int cap);
    write_reg(CFG_TURN_GAIN, tg);
    write_reg(CFG_DRIVE_GAIN, dg);
    write_reg(CFG_ANGLE_DB, adb);
    write_reg(CFG_DIST_DB, ddb);
    write_reg(CFG_WIN_HIGH, hi);
    write_reg(CFG_WIN_LOW, lo);
    write_reg(CFG_SPEED_CAP, cap);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One approach: a start pose, a goal, poses aimed at it that close in, the last one near the goal.
  task automatic approach(output int sent);
    int sx, sy, tx, ty, aim, steps, px, py;
    real ang;
    sx = clip16(clamp_win($urandom_range(0, 6000) - 3000) + $urandom_range(0, 2000) - 1000);
    sy = clip16(clamp_win($urandom_range(0, 6000) - 3000) + $urandom_range(0, 2000) - 1000);
    send_pose(sx, sy, $urandom_range(0, 25736) - 12868);
    if ($urandom_range(0, 4) == 0) begin
      send_goal($urandom, $urandom);
    end else begin
      send_goal(clip16($urandom_range(0, 8000) - 4000), clip16($urandom_range(0, 8000) - 4000));
    end
    tx = clamp_win(goal_x_i);
    ty = clamp_win(goal_y_i);
    ang = $atan2(real'(ty - sy), real'(tx - sx)) * 4096.0;
    aim = $rtoi(ang + ((ang < 0) ? -0.5 : 0.5));
    steps = $urandom_range(2, 8);
    sent = 2 + steps;
    for (int k = 1; k <= steps; k++) begin
      if (k == steps) begin
        px = clip16(tx + $urandom_range(0, 30) - 15);
        py = clip16(ty + $urandom_range(0, 30) - 15);
      end else begin
        px = sx + (tx - sx) * k / steps;
        py = sy + (ty - sy) * k / steps;
      end
      send_pose(px, py, clip_heading(aim + $urandom_range(0, 60) - 30));
      // Now and then a new goal arrives while the block is busy.
      if ($urandom_range(0, 19) == 0) begin
        send_goal(clip16(tx + $urandom_range(0, 200) - 100), ty);
        sent++;
      end
    end
  endtask

  initial begin
    int sent, total;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    goal_x_i = '0;
    goal_y_i = '0;
    pose_x_i = '0;
    pose_y_i = '0;
    pose_heading_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: goal before any pose, poses, both vector halves, extremes, busy goal.
    send_goal(1000, 500);
    send_pose(0, 0, 0);
    send_pose(0, 0, 12868);
    send_pose(0, 0, -12868);
    send_pose(-32768, 32767, 1000);
    send_goal(32767, -32768);
    send_pose(3000, -100, 0);
    send_pose(3000, 100, -12868);
    send_goal(0, 0);
    send_pose(0, 0, 0);
    send_pose(50, 50, 0);
    drain();
    configure(65535, 65535, 12868, 0, 32767, -32768, 32767);
    send_pose(100, 200, 3000);
    send_goal(-32768, -32768);
    send_pose(32767, 32767, 0);
    send_goal(32767, 32767);
    send_pose(-32768, -32768, 1000);
    drain();
    configure(0, 0, 0, 32767, -100, 100, 0);
    send_goal(500, -500);
    send_pose(0, 0, 12868);
    send_goal(-500, 500);
    send_pose(100, 100, -12868);
    send_pose(0, 0, 0);
    drain();

    // Random phases, each behind its own register setting.
    total = 0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: configure(256, 256, 41, 26, 2816, 0, 512);
        1: configure(65535, 65535, 12868, 0, 32767, -32768, 32767);
        2: configure(1024, 512, 200, 60, 16000, -16000, 4000);
        3: configure(0, 0, 0, 32767, -2000, 2000, 0);
        default: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 400), $urandom_range(0, 300),
                           $urandom_range(0, 32767), $urandom_range(0, 32768) - 32768,
                           $urandom_range(0, 32767));
      endcase
      while (total < (ph + 1) * 157) begin
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 1) == 0) send_goal($urandom, $urandom);
          else send_pose($urandom, $urandom, $urandom_range(0, 25736) - 12868);
          total++;
        end else begin
          approach(sent);
          total += sent;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gtg_pkg.sv
rtl/go_to_goal_p_controller.sv
dv/go_to_goal_p_controller_checker.sv
dv/go_to_goal_p_controller_test.sv
